// File: rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 4;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Field widths on the ports
  localparam int ACT_W      = 2;
  localparam int ID_FIELD_W = 16;
  localparam int PR_FIELD_W = 4;
  localparam int ST_W       = 2;
  localparam int OCC_W      = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam int IN_ID_LSB = ACT_W;
  localparam int IN_PR_LSB = IN_ID_LSB + ID_FIELD_W;

  // Action codes on the input channel
  localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REM = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_REM,
    OP_NOP
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } cmd_t;

endpackage

// File: rtl/spq_front.sv
// Front end: accepts input items, decodes the action and buffers the
// command in a two-entry queue towards the back end. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           cmd_valid,
  output spq_pkg::cmd_t                  cmd,
  input  logic                           cmd_ready
);
  import spq_pkg::*;

  cmd_t             q_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  cmd_t             dec;
  logic [ACT_W-1:0] action;
  logic             push, pop;

  assign action = in_tdata[ACT_W-1:0];

  always_comb begin
    unique case (action)
      ACT_ENQ: dec.op = OP_ENQ;
      ACT_DEQ: dec.op = OP_DEQ;
      ACT_REM: dec.op = OP_REM;
      ACT_NOP: dec.op = OP_NOP;
      default: dec.op = OP_NOP;
    endcase
    dec.id   = ID_BITS'(in_tdata[IN_ID_LSB +: ID_FIELD_W]);
    dec.prio = PRIO_BITS'(in_tdata[IN_PR_LSB +: PR_FIELD_W]);
  end

  assign in_tready = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/spq_back.sv
// Back end: sorted slot array with parallel compare and the registered
// result stage; one command a cycle unless a stalled result holds it. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  spq_pkg::cmd_t                   cmd,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import spq_pkg::*;

  logic [ID_BITS-1:0]   slot_id_r   [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio_r [DEPTH];
  logic [ID_BITS-1:0]   slot_id_nxt   [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio_nxt [DEPTH];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [DEPTH-1:0] held, after, match, first, below, drop_mask;
  logic             found, full, empty, do_ins, do_drop, step;

  status_t              status;
  logic [ID_BITS-1:0]   res_id;
  logic [PRIO_BITS-1:0] res_prio;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign cmd_ready = !out_valid_r || out_tready;
  assign step      = cmd_valid && cmd_ready;
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);

  // Slot flags; entries at or past the fill count are never looked at
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      held[k]  = (CNT_W'(k) < cnt_r);
      after[k] = !(held[k] && (slot_prio_r[k] <= cmd.prio));
      match[k] = held[k] && (slot_id_r[k] == cmd.id);
    end
  end

  // Isolate the match nearest the front; below marks the slots ahead of it
  assign found = |match;
  assign first = match & (~match + DEPTH'(1));
  assign below = first - DEPTH'(1);
  assign drop_mask = (cmd.op == OP_DEQ) ? {DEPTH{1'b1}} : ~below;

  assign do_ins  = (cmd.op == OP_ENQ) && !full;
  assign do_drop = ((cmd.op == OP_DEQ) && !empty) || ((cmd.op == OP_REM) && found);

  // Per slot: insert shifts towards the back, drop closes the gap forwards
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      slot_id_nxt[k]   = slot_id_r[k];
      slot_prio_nxt[k] = slot_prio_r[k];
      if (do_ins && after[k]) begin
        if (k == 0) begin
          slot_id_nxt[k]   = cmd.id;
          slot_prio_nxt[k] = cmd.prio;
        end else if (!after[(k == 0) ? 0 : k - 1]) begin
          slot_id_nxt[k]   = cmd.id;
          slot_prio_nxt[k] = cmd.prio;
        end else begin
          slot_id_nxt[k]   = slot_id_r[(k == 0) ? 0 : k - 1];
          slot_prio_nxt[k] = slot_prio_r[(k == 0) ? 0 : k - 1];
        end
      end else if (do_drop && drop_mask[k] && (k < DEPTH - 1)) begin
        slot_id_nxt[k]   = slot_id_r[(k < DEPTH - 1) ? k + 1 : k];
        slot_prio_nxt[k] = slot_prio_r[(k < DEPTH - 1) ? k + 1 : k];
      end
    end
  end

  always_comb begin
    status   = ST_OK;
    res_id   = '0;
    res_prio = '0;
    cnt_nxt  = cnt_r;
    case (cmd.op)
      OP_ENQ: begin
        if (full) status = ST_FULL;
        else      cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_DEQ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          res_id   = slot_id_r[0];
          res_prio = slot_prio_r[0];
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      OP_REM: begin
        if (!found) status = ST_NOTFOUND;
        else        cnt_nxt = cnt_r - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (step) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({OCC_W'(cnt_nxt), PR_FIELD_W'(res_prio),
                                    ID_FIELD_W'(res_id), ST_W'(status)});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (step) begin
      for (int k = 0; k < DEPTH; k++) begin
        slot_id_r[k]   <= slot_id_nxt[k];
        slot_prio_r[k] <= slot_prio_nxt[k];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: front end and command queue
// feeding the sorted-slot back end. Uses spq_pkg, spq_front, spq_back.
//
//   channel | dir | tdata fields, lowest bit first
//   in_     | in  | action[1:0], item_id[17:2], item_priority[21:18], zero pad
//   out_    | out | status[1:0], out_id[17:2], out_priority[21:18],
//           |     | occupancy[26:22], zero pad
//
// One item per cycle sustained while out_ is not stalled; each item is
// decoded into a two-entry command queue and executed by the back end,
// where all slots compare against it in parallel. The item is registered
// in the command queue, then the back end executes it and loads the result
// register. Synchronous active-low reset empties the queue.
// A stall on out_ holds the result register; the command queue then fills
// and in_tready drops after two further items.
`timescale 1ns / 1ps

module stable_priority_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]  in_tdata,   // action, item_id, item_priority
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0] out_tdata   // status, out_id, out_priority, occupancy
);
  import spq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  spq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  spq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/sv/stable_priority_queue_tb.sv
// Self-checking testbench for the stable priority queue: a directed table, then random runs.
// An in-bench sorted-slot model predicts each result. Depends on spq_pkg and stable_priority_queue.
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [OCC_W-1:0]     occ;
  } queue_result_t;

  typedef struct {
    op_t                  op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    int                   reps;   // id steps by one on each repeat
    bit                   typed;
    queue_result_t        res;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // action, item_id, item_priority, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // status, out_id, out_priority, occupancy, zero pad

  // Model of the slot store, front at index 0
  logic [ID_BITS-1:0]   model_id   [DEPTH];
  logic [PRIO_BITS-1:0] model_prio [DEPTH];
  int                   model_held = 0;

  queue_result_t pending_results [$];
  queue_result_t seen_res;
  queue_result_t want_res;
  int            fail_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            hold_reqs = 0;
  int            hold_seen = 0;
  int            hold_left = 0;

  localparam int NUM_ROWS = 21;
  directed_row_t directed_rows [NUM_ROWS] = '{
    '{OP_DEQ, 16'h0000, 4'h0, 1, 1'b1, '{ST_EMPTY,    16'h0000, 4'h0, 5'd0}},
    '{OP_REM, 16'h1234, 4'h0, 1, 1'b1, '{ST_NOTFOUND, 16'h0000, 4'h0, 5'd0}},
    '{OP_NOP, 16'hffff, 4'hf, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd0}},
    '{OP_ENQ, 16'hffff, 4'hf, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd1}},
    '{OP_ENQ, 16'h0000, 4'h0, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd2}},
    '{OP_ENQ, 16'h0001, 4'h0, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd3}},
    '{OP_ENQ, 16'h00ff, 4'hf, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd4}},
    '{OP_DEQ, 16'h0000, 4'h0, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd3}},
    '{OP_DEQ, 16'h0000, 4'h0, 1, 1'b1, '{ST_OK,       16'h0001, 4'h0, 5'd2}},
    '{OP_ENQ, 16'haaaa, 4'h7, 1, 1'b0, '0},
    '{OP_ENQ, 16'h5555, 4'h7, 1, 1'b0, '0},
    '{OP_ENQ, 16'haaaa, 4'h3, 1, 1'b0, '0},   // duplicate id, nearer the front
    '{OP_REM, 16'haaaa, 4'h0, 1, 1'b0, '0},
    '{OP_REM, 16'h9999, 4'h0, 1, 1'b0, '0},
    '{OP_DEQ, 16'h0000, 4'h0, 1, 1'b0, '0},
    '{OP_ENQ, 16'h0f00, 4'h8, 13, 1'b0, '0},  // fills the queue
    '{OP_ENQ, 16'h1357, 4'h2, 1, 1'b1, '{ST_FULL,     16'h0000, 4'h0, 5'd16}},
    '{OP_REM, 16'hffff, 4'h0, 1, 1'b0, '0},
    '{OP_NOP, 16'h0000, 4'h0, 1, 1'b1, '{ST_OK,       16'h0000, 4'h0, 5'd15}},
    '{OP_DEQ, 16'h0000, 4'h0, 15, 1'b0, '0},
    '{OP_DEQ, 16'h0000, 4'h0, 1, 1'b1, '{ST_EMPTY,    16'h0000, 4'h0, 5'd0}}
  };

  stable_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("stable_priority_queue test failed");
    $finish;
  end

  function automatic void close_gap(int pos);
    for (int k = pos; k + 1 < model_held; k++) begin
      model_id[k]   = model_id[k + 1];
      model_prio[k] = model_prio[k + 1];
    end
    model_held--;
  endfunction

  function automatic queue_result_t predict_queue_op(op_t op, logic [ID_BITS-1:0] id,
                                                     logic [PRIO_BITS-1:0] prio);
    queue_result_t r;
    int            pos;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (model_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < model_held && model_prio[pos] <= prio) pos++;
          for (int k = model_held; k > pos; k--) begin
            model_id[k]   = model_id[k - 1];
            model_prio[k] = model_prio[k - 1];
          end
          model_id[pos]   = id;
          model_prio[pos] = prio;
          model_held++;
        end
      end
      OP_DEQ: begin
        if (model_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id   = model_id[0];
          r.prio = model_prio[0];
          close_gap(0);
        end
      end
      OP_REM: begin
        pos = -1;
        for (int k = 0; k < model_held && pos < 0; k++) begin
          if (model_id[k] == id) pos = k;
        end
        if (pos < 0) r.status = ST_NOTFOUND;
        else close_gap(pos);
      end
      default: ;
    endcase
    r.occ = OCC_W'(model_held);
    return r;
  endfunction

  // Offer one item, wait for the handshake, then queue what it should produce
  task automatic send_item(op_t op, logic [ID_BITS-1:0] id, logic [PRIO_BITS-1:0] prio,
                           bit typed, queue_result_t typed_res);
    queue_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, prio, id, op};
    do @(posedge clk); while (!in_tready);
    pred = predict_queue_op(op, id, prio);
    if (typed) pred = typed_res;
    pending_results = {pending_results, pred};
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_run(int n, int enq_pct);
    int                   r;
    op_t                  op;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 4) op = OP_NOP;
      else if (r < 4 + enq_pct) op = OP_ENQ;
      else if (r[0]) op = OP_DEQ;
      else op = OP_REM;
      // removes mostly aim at a held id; a small id pool makes duplicates common
      if (op == OP_REM && model_held > 0 && $urandom_range(9) < 7)
        id = model_id[$urandom_range(model_held - 1)];
      else if ($urandom_range(1))
        id = ID_BITS'($urandom_range(15));
      else
        id = ID_BITS'($urandom);
      prio = PRIO_BITS'($urandom_range(15));
      send_item(op, id, prio, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_item(directed_rows[i].op, ID_BITS'(directed_rows[i].id + k), directed_rows[i].prio,
                  directed_rows[i].typed, directed_rows[i].res);
    end

    idle_pct = 0;  stall_pct = 0;  random_run(170, 60);
    idle_pct = 78; stall_pct = 0;  random_run(170, 45);
    idle_pct = 0;  stall_pct = 78; random_run(170, 60);
    idle_pct = 18; stall_pct = 18; random_run(170, 45);

    // Sender pauses for the last result, then the receiver holds off while items keep coming
    in_tvalid <= 1'b0;
    wait_drained();
    idle_pct  = 0;
    stall_pct = 0;
    hold_reqs = hold_reqs + 1;
    random_run(30, 60);

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("stable_priority_queue test passed");
    end else begin
      $display("stable_priority_queue test failed");
    end
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen  <= hold_reqs;
      hold_left  <= 100;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = {out_tdata[1:0], out_tdata[17:2], out_tdata[21:18], out_tdata[26:22]};
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d id %h prio %0d occ %0d",
                 $time, seen_res.status, seen_res.id, seen_res.prio, seen_res.occ);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (seen_res.status !== want_res.status || seen_res.id !== want_res.id ||
            seen_res.prio !== want_res.prio || seen_res.occ !== want_res.occ) begin
          $display("%0t: mismatch: expected status %0d id %h prio %0d occ %0d,",
                   $time, want_res.status, want_res.id, want_res.prio, want_res.occ,
                   " got status %0d id %h prio %0d occ %0d",
                   seen_res.status, seen_res.id, seen_res.prio, seen_res.occ);
          fail_count++;
        end
      end
    end
  end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_front.sv
rtl/spq_back.sv
rtl/stable_priority_queue.sv
tb/sv/stable_priority_queue_tb.sv
